// ----- hdl/color_blend_unit_top_defines.svh -----
// Assertion macros shared by the colour blend unit.
`ifndef COLOR_BLEND_UNIT_TOP_DEFINES_SVH
`define COLOR_BLEND_UNIT_TOP_DEFINES_SVH

// Checks that cons holds in the cycle after ante, outside reset.
`define CBU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Checks that cons holds in the same cycle as ante, outside reset.
`define CBU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/cbu_pkg.sv -----
// Types, codes and arithmetic helpers of the colour blend unit.
package cbu_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned NUM_CH   = 4;
    localparam int unsigned PROD_W   = 2 * CH_W;
    localparam int unsigned FACTOR_W = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CH_W-1:0]   UNORM_MAX = 8'hFF;
    localparam logic [PROD_W-1:0] ROUND_BIAS = 16'd127;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] colour_t;

    // Blend factor codes; codes ten to fifteen select zero.
    typedef enum logic [FACTOR_W-1:0] {
        FACT_ONE           = 4'd0,
        FACT_ZERO          = 4'd1,
        FACT_SRC_ALPHA     = 4'd2,
        FACT_INV_SRC_ALPHA = 4'd3,
        FACT_DST_ALPHA     = 4'd4,
        FACT_INV_DST_ALPHA = 4'd5,
        FACT_SRC_COLOUR    = 4'd6,
        FACT_INV_SRC_COLOUR = 4'd7,
        FACT_DST_COLOUR    = 4'd8,
        FACT_INV_DST_COLOUR = 4'd9
    } factor_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_FACTOR   = 2'd1;

    // Factor value for one channel. Scaling by 255 reproduces the colour
    // exactly after rounding, so factor one needs no bypass.
    function automatic chan_t cbu_factor(input logic [FACTOR_W-1:0] code,
                                         input chan_t src_alpha,
                                         input chan_t dst_alpha,
                                         input chan_t src_ch,
                                         input chan_t dst_ch);
        chan_t f;
        unique case (code)
            FACT_ONE:            f = UNORM_MAX;
            FACT_ZERO:           f = '0;
            FACT_SRC_ALPHA:      f = src_alpha;
            FACT_INV_SRC_ALPHA:  f = UNORM_MAX - src_alpha;
            FACT_DST_ALPHA:      f = dst_alpha;
            FACT_INV_DST_ALPHA:  f = UNORM_MAX - dst_alpha;
            FACT_SRC_COLOUR:     f = src_ch;
            FACT_INV_SRC_COLOUR: f = UNORM_MAX - src_ch;
            FACT_DST_COLOUR:     f = dst_ch;
            FACT_INV_DST_COLOUR: f = UNORM_MAX - dst_ch;
            default:             f = '0;
        endcase
        return f;
    endfunction

    // Floor division by 255 for values below 65280, by shift and add.
    function automatic chan_t cbu_div255(input logic [PROD_W-1:0] y);
        logic [PROD_W-1:0] t;
        t = y + {8'd0, y[PROD_W-1:CH_W]} + 16'd1;
        return t[PROD_W-1:CH_W];
    endfunction

endpackage

// ----- hdl/color_blend_unit_top.sv -----
// Colour blend unit: four-stage pipelined source plus destination blend.
// Throughput: one pixel per clock; the pipeline advances whenever its last
// stage is empty or its result is taken, so a stall holds every stage in place.
// Reset (aresetn low at a clock edge) empties the pipeline and sets the
// source factor to one and the destination factor to zero.
`include "color_blend_unit_top_defines.svh"

module color_blend_unit_top
    import cbu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [FACTOR_W-1:0]      cfg_wdata,
    // Input pixel stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // From bit 0: src_c0, src_c1, src_c2, src_c3, dst_c0, dst_c1, dst_c2, dst_c3
    input  logic [2*NUM_CH*CH_W-1:0] s_tdata,
    // Result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // From bit 0: out_c0, out_c1, out_c2, out_c3
    output logic [NUM_CH*CH_W-1:0]   m_tdata
);

    // Blend factor registers, captured by the first stage of each transaction.
    logic [FACTOR_W-1:0] src_factor_reg;
    logic [FACTOR_W-1:0] dst_factor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_factor_reg <= FACT_ONE;
            dst_factor_reg <= FACT_ZERO;
        end else if (cfg_we) begin
            // Writes to indexes beyond the register list are dropped.
            if (cfg_index == REG_SOURCE_FACTOR) begin
                src_factor_reg <= cfg_wdata;
            end else if (cfg_index == REG_DEST_FACTOR) begin
                dst_factor_reg <= cfg_wdata;
            end
        end
    end

    // The whole pipeline moves together; it may move when the output stage
    // is empty or is being emptied this cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic pipe_en;

    assign pipe_en  = !v4_reg || m_tready;
    assign s_tready = pipe_en;

    // Unpack the input transaction.
    colour_t in_src, in_dst;
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            in_src[i] = s_tdata[i*CH_W +: CH_W];
            in_dst[i] = s_tdata[(NUM_CH+i)*CH_W +: CH_W];
        end
    end

    // Stage 1: look up the factor of every channel of both terms.
    colour_t tgt_src_reg, tgt_dst_reg, fac_src_reg, fac_dst_reg;
    colour_t fac_src_next, fac_dst_next;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            fac_src_next[i] = cbu_factor(src_factor_reg, in_src[0], in_dst[0],
                                         in_src[i], in_dst[i]);
            fac_dst_next[i] = cbu_factor(dst_factor_reg, in_src[0], in_dst[0],
                                         in_src[i], in_dst[i]);
        end
    end

    // Stage 2: one 8 by 8 multiply per channel and term, with the rounding bias.
    logic [NUM_CH-1:0][PROD_W-1:0] prod_src_reg, prod_dst_reg;
    logic [NUM_CH-1:0][PROD_W-1:0] prod_src_next, prod_dst_next;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            prod_src_next[i] = PROD_W'(tgt_src_reg[i] * fac_src_reg[i]) + ROUND_BIAS;
            prod_dst_next[i] = PROD_W'(tgt_dst_reg[i] * fac_dst_reg[i]) + ROUND_BIAS;
        end
    end

    // Stage 3: divide by 255 to give the rounded unorm products.
    colour_t term_src_reg, term_dst_reg;
    colour_t term_src_next, term_dst_next;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            term_src_next[i] = cbu_div255(prod_src_reg[i]);
            term_dst_next[i] = cbu_div255(prod_dst_reg[i]);
        end
    end

    // Stage 4: add the two terms and saturate at 255.
    colour_t out_reg, out_next;

    always_comb begin
        logic [CH_W:0] sum;
        for (int i = 0; i < NUM_CH; i++) begin
            sum = {1'b0, term_src_reg[i]} + {1'b0, term_dst_reg[i]};
            out_next[i] = sum[CH_W] ? UNORM_MAX : sum[CH_W-1:0];
        end
    end

    // Valid bits travel beside the data; they alone are reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            tgt_src_reg  <= in_src;
            tgt_dst_reg  <= in_dst;
            fac_src_reg  <= fac_src_next;
            fac_dst_reg  <= fac_dst_next;
            prod_src_reg <= prod_src_next;
            prod_dst_reg <= prod_dst_next;
            term_src_reg <= term_src_next;
            term_dst_reg <= term_dst_next;
            out_reg      <= out_next;
        end
    end

    assign m_tvalid = v4_reg;
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            m_tdata[i*CH_W +: CH_W] = out_reg[i];
        end
    end

    // A held pipeline keeps every valid bit as it was.
    `CBU_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
    // An accepted transaction lands in the first stage.
    `CBU_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v1_reg)
    // A moving pipeline shifts the third stage into the output.
    `CBU_ASSERT_NEXT(a_shift_out, pipe_en, m_tvalid == $past(v3_reg))
    // The input side stalls only behind a result that is not taken.
    `CBU_ASSERT_SAME(a_ready_rule, !s_tready, m_tvalid && !m_tready)

endmodule

// ----- verif/color_blend_unit_checker.sv -----
// Checker of the colour blend unit: follows the register writes and both streams.
`timescale 1ns / 1ps

module color_blend_unit_checker
    import cbu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [FACTOR_W-1:0]      cfg_wdata,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [2*NUM_CH*CH_W-1:0] s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [NUM_CH*CH_W-1:0]   m_tdata,
    output int                       mismatches,
    output int                       outstanding,
    output int                       pixels_checked
);

    localparam int MAX_REPORTS = 50;

    logic [FACTOR_W-1:0] source_code;
    logic [FACTOR_W-1:0] dest_code;
    colour_t             expected_pixels[$];
    int                  reports_printed;

    // Rounded unorm product: (a*b + 127) / 255.
    function automatic chan_t unorm_product(input chan_t a, input chan_t b);
        int unsigned p;
        p = a;
        p = p * b + 127;
        return chan_t'(p / 255);
    endfunction

    function automatic colour_t scaled_term(input colour_t target, input colour_t src,
                                            input colour_t dst,
                                            input logic [FACTOR_W-1:0] code);
        colour_t term;
        for (int i = 0; i < NUM_CH; i++) begin
            case (code)
                FACT_ONE:            term[i] = target[i];
                FACT_ZERO:           term[i] = '0;
                FACT_SRC_ALPHA:      term[i] = unorm_product(target[i], src[0]);
                FACT_INV_SRC_ALPHA:  term[i] = unorm_product(target[i], UNORM_MAX - src[0]);
                FACT_DST_ALPHA:      term[i] = unorm_product(target[i], dst[0]);
                FACT_INV_DST_ALPHA:  term[i] = unorm_product(target[i], UNORM_MAX - dst[0]);
                FACT_SRC_COLOUR:     term[i] = unorm_product(target[i], src[i]);
                FACT_INV_SRC_COLOUR: term[i] = unorm_product(target[i], UNORM_MAX - src[i]);
                FACT_DST_COLOUR:     term[i] = unorm_product(target[i], dst[i]);
                FACT_INV_DST_COLOUR: term[i] = unorm_product(target[i], UNORM_MAX - dst[i]);
                default:             term[i] = '0;
            endcase
        end
        return term;
    endfunction

    function automatic colour_t blend_pixel(input colour_t src, input colour_t dst,
                                            input logic [FACTOR_W-1:0] src_code,
                                            input logic [FACTOR_W-1:0] dst_code);
        colour_t       a;
        colour_t       b;
        colour_t       pixel;
        logic [CH_W:0] sum;
        a = scaled_term(src, src, dst, src_code);
        b = scaled_term(dst, src, dst, dst_code);
        for (int i = 0; i < NUM_CH; i++) begin
            sum = {1'b0, a[i]} + {1'b0, b[i]};
            pixel[i] = sum[CH_W] ? UNORM_MAX : sum[CH_W-1:0];
        end
        return pixel;
    endfunction

    task automatic report_error(input string msg);
        if (reports_printed < MAX_REPORTS) begin
            $display("[%0t] blend check: %s", $realtime, msg);
            reports_printed++;
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        colour_t got;
        colour_t want;
        if (!aresetn) begin
            source_code = FACT_ONE;
            dest_code   = FACT_ZERO;
            expected_pixels.delete();
        end else begin
            // The result leaving now cannot stem from the pixel entering now.
            if (m_tvalid && m_tready) begin
                got = colour_t'(m_tdata);
                if (expected_pixels.size() == 0) begin
                    report_error($sformatf("result %h arrived with none expected", got));
                end else begin
                    want = expected_pixels.pop_front();
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (got[i] !== want[i]) begin
                            report_error($sformatf("result %0d channel %0d: got %0d, expected %0d",
                                                   pixels_checked, i, got[i], want[i]));
                        end
                    end
                end
                pixels_checked++;
            end
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(blend_pixel(colour_t'(s_tdata[NUM_CH*CH_W-1:0]),
                                                      colour_t'(s_tdata[2*NUM_CH*CH_W-1:NUM_CH*CH_W]),
                                                      source_code, dest_code));
            end
            if (cfg_we) begin
                if (cfg_index == REG_SOURCE_FACTOR) begin
                    source_code = cfg_wdata;
                end else if (cfg_index == REG_DEST_FACTOR) begin
                    dest_code = cfg_wdata;
                end
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

// ----- verif/color_blend_unit_top_test.sv -----
// Testbench top of the colour blend unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module color_blend_unit_top_test;
    import cbu_pkg::*;

    // The tail after the last expected result leaves room for anything stray still in flight.
    localparam int PIPE_LATENCY  = 4;
    localparam int DRAIN_TAIL    = PIPE_LATENCY + 4;
    localparam int RANDOM_PIXELS = 400;

    // Register indexes beyond the two real ones; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

    // Receiver behaviours, each held for a random stretch of cycles.
    localparam int RX_FREE   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_STARVE = 2;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [FACTOR_W-1:0]      cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [2*NUM_CH*CH_W-1:0] s_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [NUM_CH*CH_W-1:0]   m_tdata;

    int mismatches;
    int outstanding;
    int pixels_checked;

    int pixels_sent;
    int settings_used;
    int burst_left;
    int rx_mode      = RX_FREE;
    int rx_mode_left = 0;

    color_blend_unit_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    color_blend_unit_checker blend_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked)
    );

    always #5 aclk = ~aclk;

    // The receiver switches between taking every result, taking three in four at
    // random and starving the block for long spells, so that back-pressure lands
    // on every pipeline stage, including stretches with no stall at all.
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_FREE, RX_STARVE);
            rx_mode_left = $urandom_range(20, 120);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // A channel value that favours the ends of the range, where rounding and
    // saturation are most likely to go wrong.
    function automatic chan_t random_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return chan_t'($urandom_range(1, 3));
            3:       return chan_t'($urandom_range(252, 254));
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic colour_t random_colour();
        colour_t c;
        for (int i = 0; i < NUM_CH; i++) begin
            c[i] = random_chan();
        end
        return c;
    endfunction

    // Mostly the ten defined factors, now and then one of the unused codes.
    function automatic logic [FACTOR_W-1:0] random_factor();
        if ($urandom_range(0, 4) == 0) begin
            return FACTOR_W'($urandom_range(10, 15));
        end
        return FACTOR_W'($urandom_range(FACT_ONE, FACT_INV_DST_COLOUR));
    endfunction

    // Sends one pixel transaction. The sender works in bursts: when a burst runs
    // out it may drop valid for a random gap. Valid is only lowered at a falling
    // edge where no new pixel is presented, so it never toggles within one step.
    // Called and returning at a falling edge.
    task automatic send_pixel(input colour_t src, input colour_t dst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        pixels_sent++;
    endtask

    // Holds the sender off until every expected result has come back, then lets
    // the pipeline run dry before anything else happens.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_TAIL) @(negedge aclk);
    endtask

    // Writes both factor registers on consecutive cycles; optionally it also
    // writes the two unused indexes with values that would change the blend if
    // they landed in a real register.
    task automatic program_factors(input logic [FACTOR_W-1:0] src_code,
                                   input logic [FACTOR_W-1:0] dst_code,
                                   input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SOURCE_FACTOR;
        cfg_wdata <= src_code;
        @(negedge aclk);
        cfg_index <= REG_DEST_FACTOR;
        cfg_wdata <= dst_code;
        @(negedge aclk);
        if (poke_unused) begin
            cfg_index <= REG_UNUSED_LO;
            cfg_wdata <= ~src_code;
            @(negedge aclk);
            cfg_index <= REG_UNUSED_HI;
            cfg_wdata <= ~dst_code;
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int      quota;
        colour_t src;
        colour_t dst;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SOURCE_FACTOR;
        cfg_wdata    = FACT_ONE;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        burst_left   = 0;
        pixels_sent   = 0;
        settings_used = 1;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. First the reset setting (source passes through, the
        // destination term is zero) with all-zero and all-full pixels.
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('1, '0);
        drain_pipeline();

        // Every defined factor on each side once, with alphas and colours at the
        // ends of the range so that one-minus forms and full scaling both show.
        for (int k = FACT_ONE; k <= FACT_INV_DST_COLOUR; k++) begin
            program_factors(FACTOR_W'(k), FACTOR_W'(FACT_INV_DST_COLOUR - k), k == 4);
            src = {8'hFF, 8'h01, 8'h80, (k % 2) ? 8'h00 : 8'hFF};
            dst = {8'h00, 8'hFE, 8'h7F, (k % 3) ? 8'hFF : 8'h40};
            send_pixel(src, dst);
            drain_pipeline();
        end

        // The unused codes must all blend as zero.
        program_factors(4'd10, 4'd15, 1'b1);
        send_pixel('1, '1);
        drain_pipeline();
        program_factors(4'd12, 4'd13, 1'b0);
        send_pixel({8'h80, 8'h7F, 8'h01, 8'hFE}, '1);
        drain_pipeline();
        program_factors(4'd14, 4'd11, 1'b0);
        send_pixel('1, {8'h55, 8'hAA, 8'h01, 8'hFF});
        drain_pipeline();

        // Random part. The first settings are forced to the extremes: both
        // factors one, so that nearly every channel saturates; both the last
        // defined factor; and the top unused code on the source side.
        quota = 0;
        for (int phase = 0; quota < RANDOM_PIXELS; phase++) begin
            int count;
            case (phase)
                0:       program_factors(FACT_ONE, FACT_ONE, 1'b0);
                1:       program_factors(FACT_INV_DST_COLOUR, FACT_INV_DST_COLOUR, 1'b0);
                2:       program_factors(4'd15, FACT_SRC_COLOUR, 1'b0);
                default: program_factors(random_factor(), random_factor(),
                                         $urandom_range(0, 5) == 0);
            endcase
            count = $urandom_range(10, 50);
            for (int n = 0; n < count; n++) begin
                send_pixel(random_colour(), random_colour());
            end
            quota += count;
            // Registers may only change once the block has gone idle.
            drain_pipeline();
        end

        $display("Sent %0d pixel transactions under %0d blend factor settings; %0d compared.",
                 pixels_sent, settings_used, pixels_checked);
        $display("Covered defined and unused factor codes, ignored indexes, saturation, stalls.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guards against a hang, such as a result that never comes back.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cbu_pkg.sv
hdl/color_blend_unit_top.sv
verif/color_blend_unit_checker.sv
verif/color_blend_unit_top_test.sv
